// File: design/shared_factor_connectivity_macros.svh
// Assertion macros shared by the shared factor connectivity block.
`ifndef SHARED_FACTOR_CONNECTIVITY_MACROS_SVH
`define SHARED_FACTOR_CONNECTIVITY_MACROS_SVH
`ifndef SYNTHESIS
`define SFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SFC_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SFC_ASSERT(lbl, prop, msg)
`define SFC_ASSERT_ANY(lbl, prop, msg)
`endif
`endif

// File: design/sfc_pkg.sv
// Package: constants and controller/datapath interface types.
`default_nettype none
package sfc_pkg;
  localparam int SFC_MAX_ITEMS     = 1024;
  localparam int SFC_VALUE_BITS    = 17;
  localparam int SFC_EPOCH_BITS    = 8;
  localparam int SFC_FIRST_DIVISOR = 2;

  typedef struct packed {
    logic take_input;
    logic accept_item;
    logic set_ovf;
    logic div_start;
    logic div_take;
    logic d_inc;
    logic note_d;
    logic note_tail;
    logic own_rd;
    logic own_wr;
    logic fa_init;
    logic fa_step;
    logic fb_init;
    logic fb_step;
    logic rd_b;
    logic merge;
    logic emit;
    logic clear_step;
  } sfc_cmd_t;

  typedef struct packed {
    logic sq_le;
    logic div_done;
    logic rem_zero;
    logic rest_gt1;
    logic own_hit;
    logic pa_root;
    logic pb_root;
    logic full;
    logic last_q;
    logic epoch_wrap;
    logic clear_done;
    logic out_busy;
  } sfc_status_t;
endpackage
`default_nettype wire

// File: design/sfc_divider.sv
// Iterative restoring divider: one quotient bit per cycle.
`default_nettype none
module sfc_divider import sfc_pkg::*; #(
  parameter int VALUE_BITS = SFC_VALUE_BITS,
  parameter int D_BITS     = (SFC_VALUE_BITS + 1) / 2 + 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [VALUE_BITS-1:0] dividend,
  input  wire logic [D_BITS-1:0]     divisor,
  output logic                       done,
  output logic [VALUE_BITS-1:0]      quotient,
  output logic [D_BITS-1:0]          remainder
);
  localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

  logic [CNT_BITS-1:0] count;
  logic                busy;
  logic [D_BITS-1:0]   dvs;
  logic [D_BITS:0]     shifted;
  logic [D_BITS:0]     diff;
  logic                ge;

  // Trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    shifted = {remainder, quotient[VALUE_BITS-1]};
    diff    = shifted - {1'b0, dvs};
    ge      = shifted >= {1'b0, dvs};
  end

  // Control: count the quotient bits, pulse done at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_BITS'(VALUE_BITS);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift in one dividend bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[VALUE_BITS-2:0], ge};
      remainder <= ge ? diff[D_BITS-1:0] : shifted[D_BITS-1:0];
    end
  end
endmodule
`default_nettype wire

// File: design/sfc_datapath.sv
// Datapath: item registers, prime-owner and parent memories, result register.
`default_nettype none
module sfc_datapath import sfc_pkg::*; #(
  parameter int MAX_ITEMS  = SFC_MAX_ITEMS,
  parameter int VALUE_BITS = SFC_VALUE_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [VALUE_BITS-1:0] value,
  input  wire logic                  last,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic                       all_connected,
  output logic                       overflow,
  input  wire sfc_cmd_t              cmd,
  output sfc_status_t                st
);
  localparam int ITEM_BITS  = $clog2(MAX_ITEMS);
  localparam int COUNT_BITS = $clog2(MAX_ITEMS + 1);
  localparam int D_BITS     = (VALUE_BITS + 1) / 2 + 1;
  localparam int SQ_BITS    = 2 * D_BITS;
  localparam int OWN_DEPTH  = 2 ** VALUE_BITS;
  localparam int OWN_BITS   = SFC_EPOCH_BITS + ITEM_BITS;

  logic [VALUE_BITS-1:0]     v;
  logic [VALUE_BITS-1:0]     rest;
  logic [VALUE_BITS-1:0]     prime;
  logic [D_BITS-1:0]         d;
  logic [ITEM_BITS-1:0]      item;
  logic [ITEM_BITS-1:0]      a_node;
  logic [ITEM_BITS-1:0]      b_node;
  logic [ITEM_BITS-1:0]      ra;
  logic [COUNT_BITS-1:0]     item_count;
  logic [COUNT_BITS-1:0]     comp_count;
  logic                      ovf_seen;
  logic                      last_q;
  logic [SFC_EPOCH_BITS-1:0] epoch;
  logic [VALUE_BITS-1:0]     clear_addr;

  logic [OWN_BITS-1:0]       own_mem [OWN_DEPTH];
  logic [OWN_BITS-1:0]       own_rdata;
  logic [ITEM_BITS-1:0]      par_mem [MAX_ITEMS];
  logic [ITEM_BITS-1:0]      par_rdata;

  logic [SQ_BITS-1:0]        sq;
  logic                      div_done;
  logic [VALUE_BITS-1:0]     quotient;
  logic [D_BITS-1:0]         remainder;
  logic [ITEM_BITS-1:0]      link_hi;
  logic [ITEM_BITS-1:0]      link_lo;
  logic [ITEM_BITS-1:0]      par_raddr;

  sfc_divider #(
    .VALUE_BITS(VALUE_BITS),
    .D_BITS    (D_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (rest),
    .divisor  (d),
    .done     (div_done),
    .quotient (quotient),
    .remainder(remainder)
  );

  // Square the trial divisor and merge the larger root under the smaller
  always_comb begin
    sq        = SQ_BITS'(d) * SQ_BITS'(d);
    link_hi   = (ra > b_node) ? ra : b_node;
    link_lo   = (ra > b_node) ? b_node : ra;
    par_raddr = cmd.rd_b ? b_node : a_node;
  end

  // Status towards the controller
  always_comb begin
    st.sq_le      = sq <= SQ_BITS'(v);
    st.div_done   = div_done;
    st.rem_zero   = remainder == '0;
    st.rest_gt1   = rest > VALUE_BITS'(1);
    st.own_hit    = own_rdata[OWN_BITS-1 -: SFC_EPOCH_BITS] == epoch;
    st.pa_root    = par_rdata == a_node;
    st.pb_root    = par_rdata == b_node;
    st.full       = item_count == COUNT_BITS'(MAX_ITEMS);
    st.last_q     = last_q;
    st.epoch_wrap = epoch == '1;
    st.clear_done = clear_addr == '1;
    st.out_busy   = out_valid && !out_ready;
  end

  // Prime-owner memory: entries tagged with the set epoch
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      own_mem[clear_addr] <= '0;
    end else if (cmd.own_wr) begin
      own_mem[prime] <= {epoch, item};
    end
    if (cmd.own_rd) begin
      own_rdata <= own_mem[prime];
    end
  end

  // Parent memory: self link on entry, root link on merge
  always_ff @(posedge clk) begin
    if (cmd.accept_item) begin
      par_mem[item_count[ITEM_BITS-1:0]] <= item_count[ITEM_BITS-1:0];
    end else if (cmd.merge && (ra != b_node)) begin
      par_mem[link_hi] <= link_lo;
    end
    par_rdata <= par_mem[par_raddr];
  end

  // Item payload registers
  always_ff @(posedge clk) begin
    if (cmd.take_input) begin
      last_q <= last;
    end
    if (cmd.accept_item) begin
      v    <= value;
      rest <= value;
      d    <= D_BITS'(SFC_FIRST_DIVISOR);
      item <= item_count[ITEM_BITS-1:0];
    end else begin
      if (cmd.div_take) begin
        rest <= quotient;
      end
      if (cmd.d_inc) begin
        d <= d + 1'b1;
      end
    end
    if (cmd.note_d) begin
      prime <= VALUE_BITS'(d);
    end else if (cmd.note_tail) begin
      prime <= rest;
    end
    if (cmd.fa_init) begin
      a_node <= item;
    end else if (cmd.fa_step) begin
      a_node <= par_rdata;
    end
    if (cmd.fb_init) begin
      ra     <= a_node;
      b_node <= own_rdata[ITEM_BITS-1:0];
    end else if (cmd.fb_step) begin
      b_node <= par_rdata;
    end
  end

  // Set counters, epoch, clearing sweep and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_count    <= '0;
      comp_count    <= '0;
      ovf_seen      <= 1'b0;
      epoch         <= SFC_EPOCH_BITS'(1);
      clear_addr    <= '0;
      out_valid     <= 1'b0;
      all_connected <= 1'b0;
      overflow      <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid     <= 1'b1;
        all_connected <= !ovf_seen && (comp_count <= COUNT_BITS'(1));
        overflow      <= ovf_seen;
        item_count    <= '0;
        comp_count    <= '0;
        ovf_seen      <= 1'b0;
        epoch         <= (epoch == '1) ? SFC_EPOCH_BITS'(1) : epoch + 1'b1;
        clear_addr    <= '0;
      end else begin
        if (out_ready) begin
          out_valid <= 1'b0;
        end
        if (cmd.accept_item) begin
          item_count <= item_count + 1'b1;
          comp_count <= comp_count + 1'b1;
        end else if (cmd.merge && (ra != b_node)) begin
          comp_count <= comp_count - 1'b1;
        end
        if (cmd.set_ovf) begin
          ovf_seen <= 1'b1;
        end
        if (cmd.clear_step) begin
          clear_addr <= clear_addr + 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: design/sfc_ctrl.sv
// Controller: sequences factoring, owner lookups and union-find walks.
`default_nettype none
module sfc_ctrl import sfc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        last,
  output logic             in_ready,
  output sfc_cmd_t         cmd,
  input  wire sfc_status_t st
);
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DTEST  = 4'd2;
  localparam logic [3:0] S_DIV    = 4'd3;
  localparam logic [3:0] S_REDIV  = 4'd4;
  localparam logic [3:0] S_TAIL   = 4'd5;
  localparam logic [3:0] S_NOTE   = 4'd6;
  localparam logic [3:0] S_OWN    = 4'd7;
  localparam logic [3:0] S_FA_RD  = 4'd8;
  localparam logic [3:0] S_FA_CHK = 4'd9;
  localparam logic [3:0] S_FB_RD  = 4'd10;
  localparam logic [3:0] S_FB_CHK = 4'd11;
  localparam logic [3:0] S_FINISH = 4'd12;
  localparam logic [3:0] S_RESULT = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       found;
  logic       found_next;
  logic       tail;
  logic       tail_next;
  logic [3:0] ret_state;

  assign in_ready  = state == S_IDLE;
  assign ret_state = tail ? S_FINISH : S_REDIV;

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    found_next = found;
    tail_next  = tail;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (st.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_input = 1'b1;
          if (st.full) begin
            cmd.set_ovf = 1'b1;
            state_next  = last ? S_RESULT : S_IDLE;
          end else begin
            cmd.accept_item = 1'b1;
            found_next      = 1'b0;
            tail_next       = 1'b0;
            state_next      = S_DTEST;
          end
        end
      end
      S_DTEST: begin
        if (st.sq_le) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_TAIL;
        end
      end
      S_DIV: begin
        if (st.div_done) begin
          if (st.rem_zero) begin
            cmd.div_take = 1'b1;
            if (!found) begin
              found_next  = 1'b1;
              cmd.note_d  = 1'b1;
              state_next  = S_NOTE;
            end else begin
              state_next = S_REDIV;
            end
          end else begin
            cmd.d_inc  = 1'b1;
            found_next = 1'b0;
            state_next = S_DTEST;
          end
        end
      end
      S_REDIV: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_TAIL: begin
        if (st.rest_gt1) begin
          cmd.note_tail = 1'b1;
          tail_next     = 1'b1;
          state_next    = S_NOTE;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_NOTE: begin
        cmd.own_rd = 1'b1;
        state_next = S_OWN;
      end
      S_OWN: begin
        if (st.own_hit) begin
          cmd.fa_init = 1'b1;
          state_next  = S_FA_RD;
        end else begin
          cmd.own_wr = 1'b1;
          state_next = ret_state;
        end
      end
      S_FA_RD: state_next = S_FA_CHK;
      S_FA_CHK: begin
        if (st.pa_root) begin
          cmd.fb_init = 1'b1;
          state_next  = S_FB_RD;
        end else begin
          cmd.fa_step = 1'b1;
          state_next  = S_FA_RD;
        end
      end
      S_FB_RD: begin
        cmd.rd_b   = 1'b1;
        state_next = S_FB_CHK;
      end
      S_FB_CHK: begin
        cmd.rd_b = 1'b1;
        if (st.pb_root) begin
          cmd.merge  = 1'b1;
          state_next = ret_state;
        end else begin
          cmd.fb_step = 1'b1;
          state_next  = S_FB_RD;
        end
      end
      S_FINISH: state_next = st.last_q ? S_RESULT : S_IDLE;
      S_RESULT: begin
        if (!st.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = st.epoch_wrap ? S_CLEAR : S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // State register; reset starts the owner clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      found <= 1'b0;
      tail  <= 1'b0;
    end else begin
      state <= state_next;
      found <= found_next;
      tail  <= tail_next;
    end
  end
endmodule
`default_nettype wire

// File: design/shared_factor_connectivity.sv
// Top level: shared prime factor connectivity over a set of integers.
`default_nettype none
`include "shared_factor_connectivity_macros.svh"
// Takes one value per transfer, the set ending with last; after the final
// item one transfer reports whether all items are linked through shared
// prime factors, or overflow when the set exceeded MAX_ITEMS. Items are
// handled one at a time. The iterative divider tries each trial divisor
// from 2 up to the square root of the value and divides again for each
// repeated factor; each distinct prime then takes an owner lookup and a
// walk of the union-find parents. After reset, and after every 255th
// result, a sweep over all 2^VALUE_BITS entries clears the prime-owner
// memory, and no input is taken meanwhile.
module shared_factor_connectivity import sfc_pkg::*; #(
  parameter int MAX_ITEMS  = SFC_MAX_ITEMS,
  parameter int VALUE_BITS = SFC_VALUE_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [VALUE_BITS-1:0] value,
  input  wire logic                  last,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       all_connected,
  output logic                       overflow
);
  sfc_cmd_t    cmd;
  sfc_status_t st;

  sfc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .last    (last),
    .in_ready(in_ready),
    .cmd     (cmd),
    .st      (st)
  );

  sfc_datapath #(
    .MAX_ITEMS (MAX_ITEMS),
    .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .value        (value),
    .last         (last),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .all_connected(all_connected),
    .overflow     (overflow),
    .cmd          (cmd),
    .st           (st)
  );

  // Checks
  `SFC_ASSERT(a_ovf_not_conn, (out_valid && overflow) |-> !all_connected, "overflow with connected")
  `SFC_ASSERT_ANY(a_clear_after_rst, rst |=> !in_ready, "input taken during clearing sweep")
  `SFC_ASSERT(a_no_store_full, cmd.accept_item |-> !st.full, "item stored into full table")
endmodule
`default_nettype wire
